>>> rtl/core/lattice_value_noise_hash_assert.svh
// assertion macros shared by the lattice value noise checker
`ifndef LATTICE_VALUE_NOISE_HASH_ASSERT_SVH
`define LATTICE_VALUE_NOISE_HASH_ASSERT_SVH

// property checked at every clock edge outside reset
`define LVNH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every clock edge, reset included
`define LVNH_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/lvnh_pkg.sv
// types and constants of the lattice value noise hash
package lvnh_pkg;

    localparam int COORD_W  = 16;
    localparam int DIM_W    = 3;
    localparam int SUM_W    = 34;
    localparam int FRAC_W   = 30;
    localparam int WORD_W   = 32;
    localparam int PROD_W   = 2 * WORD_W;
    localparam int HALF_W   = 17;
    localparam int PART_W   = 37;
    localparam int FULL_W   = 54;
    localparam int QUOT_W   = FULL_W - FRAC_W;
    localparam int HASH_SHL = 13;
    localparam int MASK_W   = 31;

    localparam logic [WORD_W-1:0] SCALE_MULT = 32'd850000;
    localparam logic [WORD_W-1:0] HASH_MUL   = 32'd15731;
    localparam logic [WORD_W-1:0] HASH_ADD_A = 32'd789221;
    localparam logic [WORD_W-1:0] HASH_ADD_B = 32'd1376312589;
    localparam logic [SUM_W-1:0]  ONE_FIXED  = 34'd1073741824;
    localparam logic [DIM_W-1:0]  DIM_RESET  = 3'd1;

    // operand pair for the shared multiplier
    typedef struct packed {
        logic              en;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_mul_req;

endpackage

>>> rtl/core/lvnh_mul.sv
// shared 32x32 multiplier with registered 64-bit product
module lvnh_mul (
    input  logic                          i_clk,
    input  lvnh_pkg::t_mul_req            i_req,
    output logic [lvnh_pkg::PROD_W-1:0]   o_prod
);

    logic [lvnh_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= lvnh_pkg::PROD_W'(i_req.a) * lvnh_pkg::PROD_W'(i_req.b);
        end
    end

    assign o_prod = r_prod;

endmodule

>>> rtl/core/lattice_value_noise_hash.sv
// lattice value noise hash: top level with sequencer and accumulator
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+----------------------------
//  in      | in        | i_in_valid / o_in_stall     | i_coordinate     [15:0]
//  out     | out       | o_out_valid / i_out_stall   | o_noise_value    [33:0] signed
//  cfg     | in        | i_cfg_valid / o_cfg_ready   | i_cfg_dimensions [2:0]
//
// each coordinate transaction is the accept step plus 8 sequencer steps,
// five of them on the single shared 32x32 multiplier (two partial products of the
// scaled sum, then the square, the constant and the final mix)
// synchronous active-low reset clears sum, count and output valid, sets dimensions to 1
// a finished result waits in the output register while the next coordinate is accepted;
// the sequencer holds in its last step only while a new result meets a stalled one
module lattice_value_noise_hash #(
    parameter int MAX_DIMENSIONS = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [lvnh_pkg::COORD_W-1:0]         i_coordinate,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [lvnh_pkg::SUM_W-1:0]    o_noise_value,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lvnh_pkg::DIM_W-1:0]           i_cfg_dimensions
);

    localparam int CNT_W = $clog2(MAX_DIMENSIONS + 1);
    localparam int CMP_W = (CNT_W > lvnh_pkg::DIM_W) ? CNT_W : lvnh_pkg::DIM_W;

    typedef enum logic [3:0] {
        S_IDLE,  // waiting for a coordinate
        S_LO,    // low half of |sum| times scale
        S_HI,    // high half of |sum| times scale
        S_SEED,  // seed and shift-xor
        S_SQ,    // s * s
        S_C1,    // s^2 * 15731
        S_ADD,   // + 789221
        S_MIX,   // s * t
        S_FIN    // finish hash, accumulate, maybe emit
    } t_state;

    t_state                               r_state;
    logic [lvnh_pkg::DIM_W-1:0]           r_dims;
    logic [lvnh_pkg::SUM_W-1:0]           r_sum;
    logic [CNT_W-1:0]                     r_cnt;
    logic [lvnh_pkg::COORD_W-1:0]         r_coord;
    logic [lvnh_pkg::PART_W-1:0]          r_plo;
    logic [lvnh_pkg::WORD_W-1:0]          r_s;
    logic [lvnh_pkg::WORD_W-1:0]          r_t;
    logic                                 r_out_valid;
    logic [lvnh_pkg::SUM_W-1:0]           r_out;

    lvnh_pkg::t_mul_req                   mul_req;
    logic [lvnh_pkg::PROD_W-1:0]          mul_prod;

    logic [lvnh_pkg::SUM_W-1:0]           mag;
    logic [lvnh_pkg::FULL_W-1:0]          full_prod;
    logic [lvnh_pkg::WORD_W-1:0]          quot;
    logic [lvnh_pkg::WORD_W-1:0]          n_seed;
    logic [lvnh_pkg::WORD_W-1:0]          n_s;
    logic [lvnh_pkg::WORD_W-1:0]          hash;
    logic [lvnh_pkg::SUM_W-1:0]           term;
    logic [lvnh_pkg::SUM_W-1:0]           n_sum;
    logic [CMP_W-1:0]                     cnt_inc;
    logic [CMP_W-1:0]                     dims_ext;
    logic [CMP_W-1:0]                     eff_dims;
    logic                                 point_done;
    logic                                 out_free;
    logic                                 in_accept;
    logic                                 emit;

    lvnh_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    // magnitude of the accumulator, scaled product built from two partials
    assign mag       = r_sum[lvnh_pkg::SUM_W-1] ? (~r_sum + lvnh_pkg::SUM_W'(1)) : r_sum;
    assign full_prod = {mul_prod[lvnh_pkg::PART_W-1:0], {lvnh_pkg::HALF_W{1'b0}}}
                     + lvnh_pkg::FULL_W'(r_plo);

    // quotient by 2^30, sign restored afterwards: truncation toward zero
    always_comb begin
        quot = lvnh_pkg::WORD_W'(full_prod[lvnh_pkg::FULL_W-1:lvnh_pkg::FRAC_W]);
        if (r_sum[lvnh_pkg::SUM_W-1]) begin
            quot = ~quot + lvnh_pkg::WORD_W'(1);
        end
    end

    assign n_seed = lvnh_pkg::WORD_W'(r_coord) + quot;
    assign n_s    = (n_seed << lvnh_pkg::HASH_SHL) ^ n_seed;

    assign hash  = mul_prod[lvnh_pkg::WORD_W-1:0] + lvnh_pkg::HASH_ADD_B;
    assign term  = lvnh_pkg::ONE_FIXED
                 - lvnh_pkg::SUM_W'(hash[lvnh_pkg::MASK_W-1:0]);
    assign n_sum = r_sum + term;

    // effective point length: zero counts as one, saturate at the maximum
    assign cnt_inc  = CMP_W'(r_cnt) + CMP_W'(1);
    assign dims_ext = CMP_W'(r_dims);
    always_comb begin
        if (r_dims == '0) begin
            eff_dims = CMP_W'(1);
        end else if (dims_ext > CMP_W'(MAX_DIMENSIONS)) begin
            eff_dims = CMP_W'(MAX_DIMENSIONS);
        end else begin
            eff_dims = dims_ext;
        end
    end
    assign point_done = (cnt_inc >= eff_dims);

    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign emit      = (r_state == S_FIN) && point_done && out_free;

    // operand selection for the shared multiplier
    always_comb begin
        mul_req.en = 1'b1;
        mul_req.a  = '0;
        mul_req.b  = '0;
        case (r_state)
            S_LO: begin
                mul_req.a = lvnh_pkg::WORD_W'(mag[lvnh_pkg::HALF_W-1:0]);
                mul_req.b = lvnh_pkg::SCALE_MULT;
            end
            S_HI: begin
                mul_req.a = lvnh_pkg::WORD_W'(mag[lvnh_pkg::SUM_W-1:lvnh_pkg::HALF_W]);
                mul_req.b = lvnh_pkg::SCALE_MULT;
            end
            S_SQ: begin
                mul_req.a = r_s;
                mul_req.b = r_s;
            end
            S_C1: begin
                mul_req.a = mul_prod[lvnh_pkg::WORD_W-1:0];
                mul_req.b = lvnh_pkg::HASH_MUL;
            end
            S_MIX: begin
                mul_req.a = r_s;
                mul_req.b = r_t;
            end
            default: begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dims      <= lvnh_pkg::DIM_RESET;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_dims <= i_cfg_dimensions;
            end
            // a new result replaces one leaving in the same cycle
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_coord <= i_coordinate;
                        r_state <= S_LO;
                    end
                end
                S_LO: begin
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_plo   <= mul_prod[lvnh_pkg::PART_W-1:0];
                    r_state <= S_SEED;
                end
                S_SEED: begin
                    r_s     <= n_s;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_state <= S_C1;
                end
                S_C1: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_t     <= mul_prod[lvnh_pkg::WORD_W-1:0] + lvnh_pkg::HASH_ADD_A;
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!point_done) begin
                        r_sum   <= n_sum;
                        r_cnt   <= CNT_W'(cnt_inc);
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        // last coordinate: emit and clear for the next point
                        r_out       <= n_sum;
                        r_sum       <= '0;
                        r_cnt       <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_noise_value = r_out;
    assign o_cfg_ready   = 1'b1;

endmodule

>>> rtl/core/lvnh_checker.sv
// port-level checker for the lattice value noise hash, bound to the top level
`include "lattice_value_noise_hash_assert.svh"

module lvnh_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [lvnh_pkg::SUM_W-1:0]         o_noise_value
);

    `LVNH_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_noise_value)), "stalled result changed")
    `LVNH_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "input not stalled while a coordinate is in work")
    `LVNH_ASSERT(a_no_instant_result, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> !$rose(o_out_valid), "result appeared one cycle after accept")
    `LVNH_ASSERT_ALWAYS(a_reset_clean, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall), "block not idle after reset")

endmodule

bind lattice_value_noise_hash lvnh_checker u_lvnh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_noise_value (o_noise_value)
);

>>> verif/lattice_value_noise_hash_checker.sv
// transaction monitor, noise predictor and result comparison for the lattice value noise hash
`timescale 1ns / 100ps

module lattice_value_noise_hash_checker #(
    parameter int MAX_DIMENSIONS = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic [lvnh_pkg::COORD_W-1:0]         i_coordinate,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [lvnh_pkg::SUM_W-1:0]    i_noise_value,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [lvnh_pkg::DIM_W-1:0]           i_cfg_dimensions,
    output int                                   o_pending,
    output int                                   o_fail_count
);

    logic [lvnh_pkg::DIM_W-1:0]        dims_reg;
    logic signed [lvnh_pkg::SUM_W-1:0] noise_acc;
    int                                coords_taken;
    int                                fail_total;
    logic signed [lvnh_pkg::SUM_W-1:0] expected_noise [$];

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        fail_total   = 0;
    end

    // sum scaled by 850000 / 2^30, truncated toward zero
    function automatic longint scaled_noise(input logic signed [lvnh_pkg::SUM_W-1:0] acc);
        longint prod;
        prod = longint'(acc) * longint'(lvnh_pkg::SCALE_MULT);
        if (prod < 0) begin
            return -((-prod) >>> lvnh_pkg::FRAC_W);
        end
        return prod >>> lvnh_pkg::FRAC_W;
    endfunction

    // shift-xor and cubic hash, mapped to 1 - h/2^30 in fixed point
    function automatic longint noise_hash_term(input logic [lvnh_pkg::WORD_W-1:0] seed);
        logic [lvnh_pkg::WORD_W-1:0] h;
        h = (seed << lvnh_pkg::HASH_SHL) ^ seed;
        h = h * (h * h * lvnh_pkg::HASH_MUL + lvnh_pkg::HASH_ADD_A) + lvnh_pkg::HASH_ADD_B;
        return longint'(lvnh_pkg::ONE_FIXED)
             - longint'({1'b0, h[lvnh_pkg::MASK_W-1:0]});
    endfunction

    function automatic int point_dimensions(input logic [lvnh_pkg::DIM_W-1:0] d);
        int n;
        n = int'(d);
        if (n == 0) begin
            n = 1;
        end
        if (n > MAX_DIMENSIONS) begin
            n = MAX_DIMENSIONS;
        end
        return n;
    endfunction

    always @(posedge i_clk) begin
        logic [lvnh_pkg::WORD_W-1:0]       seed;
        longint                            scaled;
        logic signed [63:0]                wide;
        logic signed [lvnh_pkg::SUM_W-1:0] want;
        if (!i_rst_n) begin
            dims_reg     = lvnh_pkg::DIM_RESET;
            noise_acc    = '0;
            coords_taken = 0;
            expected_noise.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                dims_reg = i_cfg_dimensions;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_noise.size() == 0) begin
                    $error("noise_value: unexpected result, expected none, actual %0d",
                           i_noise_value);
                    fail_total++;
                end else begin
                    want = expected_noise.pop_front();
                    if (i_noise_value !== want) begin
                        $error("noise_value mismatch: expected %0d, actual %0d",
                               want, i_noise_value);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                scaled = scaled_noise(noise_acc);
                seed   = {{(lvnh_pkg::WORD_W-lvnh_pkg::COORD_W){1'b0}}, i_coordinate}
                       + lvnh_pkg::WORD_W'(scaled);
                wide   = longint'(noise_acc) + noise_hash_term(seed);
                noise_acc = wide[lvnh_pkg::SUM_W-1:0];
                coords_taken++;
                // a lowered setting ends the point once the count reaches or passes it
                if (coords_taken >= point_dimensions(dims_reg)) begin
                    expected_noise.push_back(noise_acc);
                    noise_acc    = '0;
                    coords_taken = 0;
                end
            end
        end
        o_pending    <= expected_noise.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> verif/lattice_value_noise_hash_tb.sv
// stimulus, idling and verdict for the lattice value noise hash testbench
`timescale 1ns / 100ps

module lattice_value_noise_hash_tb;

    localparam int RANDOM_ITEMS  = 850;
    localparam int QUIET_TAIL    = 100;    // final items run with no idling at all
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off to back up the block
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 200000;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic [lvnh_pkg::COORD_W-1:0]         coordinate = '0;
    logic                                 out_stall = 1'b0;
    logic                                 cfg_valid = 1'b0;
    logic [lvnh_pkg::DIM_W-1:0]           cfg_dims = '0;
    logic                                 o_in_stall;
    logic                                 o_out_valid;
    logic signed [lvnh_pkg::SUM_W-1:0]    o_noise_value;
    logic                                 o_cfg_ready;
    int                                   pending;
    int                                   fail_count;
    int                                   cycle_count = 0;

    // shared idling controls, set by the stimulus process
    bit                   no_idle = 1'b0;
    bit                   long_hold_req = 1'b0;

    always #2 i_clk = ~i_clk;

    lattice_value_noise_hash DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_coordinate     (coordinate),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_noise_value    (o_noise_value),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_dimensions (cfg_dims)
    );

    lattice_value_noise_hash_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (o_in_stall),
        .i_coordinate     (coordinate),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .i_noise_value    (o_noise_value),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_dimensions (cfg_dims),
        .o_pending        (pending),
        .o_fail_count     (fail_count)
    );

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: short random stall bursts, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = HOLD_CYCLES;
            end else if (stall_left == 0 && !no_idle && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 4);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // one coordinate transaction, with an optional random gap in front of it
    task automatic send_coordinate(input logic [lvnh_pkg::COORD_W-1:0] c);
        int gap;
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        coordinate <= c;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop offering, wait for every expected result, then let the sequencer settle
    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // dimensions write, only ever called with the block idle
    task automatic write_dimensions(input logic [lvnh_pkg::DIM_W-1:0] d);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_dims  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [lvnh_pkg::DIM_W-1:0]   dims_plan [8];
        logic [lvnh_pkg::DIM_W-1:0]   dims;
        logic [lvnh_pkg::COORD_W-1:0] c;
        int total;
        int phase;
        int phase_len;
        int k;

        dims_plan = '{3'd2, 3'd5, 3'd3, 3'd6, 3'd1, 3'd4, 3'd7, 3'd0};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting is one coordinate per point: extremes and bit patterns
        send_coordinate(16'h0000);
        send_coordinate(16'hffff);
        send_coordinate(16'h0001);
        send_coordinate(16'h8000);
        send_coordinate(16'h5555);
        drain_results();

        // full four-dimensional points at both coordinate extremes
        write_dimensions(3'd4);
        repeat (4) send_coordinate(16'hffff);
        repeat (4) send_coordinate(16'h0000);
        drain_results();

        // zero dimensions behaves as one
        write_dimensions(3'd0);
        send_coordinate(16'haaaa);
        send_coordinate(16'h7fff);
        drain_results();

        // values past the maximum saturate
        write_dimensions(3'd7);
        repeat (4) send_coordinate(16'h1234);
        drain_results();

        // lower the setting mid-point: the next coordinate closes the point
        write_dimensions(3'd4);
        send_coordinate(16'h00ff);
        send_coordinate(16'hff00);
        send_coordinate(16'h0f0f);
        drain_results();
        write_dimensions(3'd2);
        send_coordinate(16'hf0f0);
        drain_results();

        // random phases, each with its own setting; odd phase lengths leave points
        // half finished across setting changes
        total = 0;
        phase = 0;
        while (total < RANDOM_ITEMS) begin
            drain_results();
            dims = (phase < 8) ? dims_plan[phase]
                               : lvnh_pkg::DIM_W'($urandom_range(0, 7));
            write_dimensions(dims);
            phase_len = $urandom_range(30, 110);
            no_idle   = (total >= RANDOM_ITEMS - QUIET_TAIL) || ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                // receiver backs off while coordinates keep coming
                no_idle       = 1'b0;
                long_hold_req = 1'b1;
            end
            for (k = 0; k < phase_len && total < RANDOM_ITEMS; k++) begin
                if (total >= RANDOM_ITEMS - QUIET_TAIL) begin
                    no_idle = 1'b1;
                end
                case ($urandom_range(0, 9))
                    0:       c = '0;
                    1:       c = '1;
                    2:       c = lvnh_pkg::COORD_W'($urandom_range(0, 15));
                    default: c = lvnh_pkg::COORD_W'($urandom_range(0, 65535));
                endcase
                send_coordinate(c);
                total++;
                // occasional full pause of the sender
                if ($urandom_range(0, 149) == 0) begin
                    drain_results();
                end
            end
            phase++;
        end

        drain_results();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
